[src/dbass_pkg.sv]
// Package for the double-buffered audio sample sequencer.
// Holds widths, operation and play-state codes, beat structs and the mode encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbass_pkg;

  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned LEN_BITS  = 24;
  localparam int unsigned POS_BITS  = LEN_BITS + 1;
  localparam int unsigned DIV_BITS  = 16;
  localparam int unsigned OP_BITS   = 3;
  localparam int unsigned PS_BITS   = 3;

  localparam logic [DIV_BITS-1:0] RATE_DIV_RST = DIV_BITS'(11);

  // operation codes
  localparam logic [OP_BITS-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_QUEUE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_PLAY  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PAUSE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_STOP  = 3'd4;

  // reported play state codes
  localparam logic [PS_BITS-1:0] PS_STOPPED      = 3'd0;
  localparam logic [PS_BITS-1:0] PS_PLAY_MONO    = 3'd1;
  localparam logic [PS_BITS-1:0] PS_PLAY_STEREO  = 3'd2;
  localparam logic [PS_BITS-1:0] PS_PAUSE_MONO   = 3'd3;
  localparam logic [PS_BITS-1:0] PS_PAUSE_STEREO = 3'd4;

  typedef enum logic [4:0] {
    M_STOPPED      = 5'b00001,
    M_PLAY_MONO    = 5'b00010,
    M_PLAY_STEREO  = 5'b00100,
    M_PAUSE_MONO   = 5'b01000,
    M_PAUSE_STEREO = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [ADDR_BITS-1:0] buffer_addr;
    logic [LEN_BITS-1:0]  buffer_len;
    logic                 stereo_mode;
  } item_t;

  typedef struct packed {
    logic                 fetch_valid;
    logic [ADDR_BITS-1:0] left_addr;
    logic [ADDR_BITS-1:0] right_addr;
    logic [PS_BITS-1:0]   play_state;
    logic [POS_BITS-1:0]  bytes_left;
    logic                 slot_free;
    logic [LEN_BITS-1:0]  accepted_len;
  } result_t;

  function automatic logic [PS_BITS-1:0] mode_code(input mode_e m);
    logic [PS_BITS-1:0] c;
    unique case (m)
      M_STOPPED:      c = PS_STOPPED;
      M_PLAY_MONO:    c = PS_PLAY_MONO;
      M_PLAY_STEREO:  c = PS_PLAY_STEREO;
      M_PAUSE_MONO:   c = PS_PAUSE_MONO;
      M_PAUSE_STEREO: c = PS_PAUSE_STEREO;
      default:        c = PS_STOPPED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/dbass_in_stage.sv]
// Input register of the sequencer: holds one command beat until the core takes it.
// Depends on dbass_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbass_in_stage (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  dbass_pkg::item_t   in_data_i,
  input  wire                take_i,
  output logic               full_o,
  output dbass_pkg::item_t   item_o
);
  import dbass_pkg::*;

  logic  full_q, full_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = full_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full_d     = accept || (full_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

[src/dbass_core.sv]
// Sequencer core: buffer descriptors, play mode, tick divider and the per-beat update.
// Status fields are computed from the post-update state. Depends on dbass_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbass_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                step_i,
  input  dbass_pkg::item_t                   item_i,
  input  wire                                cfg_we_i,
  input  wire [dbass_pkg::DIV_BITS-1:0]      cfg_data_i,
  output dbass_pkg::result_t                 res_o
);
  import dbass_pkg::*;

  mode_e                mode_q, mode_d;
  logic [ADDR_BITS-1:0] cur_base_q, cur_base_d;
  logic [LEN_BITS-1:0]  cur_len_q, cur_len_d;
  logic [POS_BITS-1:0]  cur_pos_q, cur_pos_d;
  logic [ADDR_BITS-1:0] pend_base_q, pend_base_d;
  logic [LEN_BITS-1:0]  pend_len_q, pend_len_d;
  logic [DIV_BITS-1:0]  tick_q, tick_d;
  logic [DIV_BITS-1:0]  rate_div_q;

  logic [DIV_BITS-1:0]  tick_inc;
  logic                 expire;
  logic [POS_BITS-1:0]  pos_adv;
  logic                 fetch;
  logic [ADDR_BITS-1:0] laddr, raddr;
  logic [LEN_BITS-1:0]  accepted;
  logic [POS_BITS-1:0]  left;

  assign tick_inc = tick_q + DIV_BITS'(1);
  assign expire   = tick_inc >= rate_div_q;
  assign laddr    = cur_base_q + ADDR_BITS'(cur_pos_q);

  always_comb begin
    mode_d      = mode_q;
    cur_base_d  = cur_base_q;
    cur_len_d   = cur_len_q;
    cur_pos_d   = cur_pos_q;
    pend_base_d = pend_base_q;
    pend_len_d  = pend_len_q;
    tick_d      = tick_q;
    fetch       = 1'b0;
    raddr       = '0;
    accepted    = '0;
    pos_adv     = cur_pos_q;

    unique case (item_i.operation)
      OP_TICK: begin
        tick_d = expire ? '0 : tick_inc;
        if (expire && cur_len_q != '0) begin
          if (mode_q == M_PLAY_MONO) begin
            fetch   = 1'b1;
            raddr   = laddr;
            pos_adv = cur_pos_q + POS_BITS'(1);
          end else if (mode_q == M_PLAY_STEREO) begin
            fetch   = 1'b1;
            raddr   = laddr + ADDR_BITS'(1);
            pos_adv = cur_pos_q + POS_BITS'(2);
          end
          cur_pos_d = pos_adv;
          // end of buffer: swap in the pending one or stop
          if (pos_adv >= POS_BITS'(cur_len_q)) begin
            if (pend_len_q != '0) begin
              cur_base_d  = pend_base_q;
              cur_len_d   = pend_len_q;
              cur_pos_d   = '0;
              pend_base_d = '0;
              pend_len_d  = '0;
            end else begin
              cur_base_d = '0;
              cur_len_d  = '0;
              cur_pos_d  = '0;
              mode_d     = M_STOPPED;
            end
          end
        end
      end
      OP_QUEUE: begin
        if (mode_q == M_STOPPED && cur_len_q == '0) begin
          cur_base_d = item_i.buffer_addr;
          cur_len_d  = item_i.buffer_len;
          accepted   = item_i.buffer_len;
        end else if (pend_len_q == '0) begin
          pend_base_d = item_i.buffer_addr;
          pend_len_d  = item_i.buffer_len;
          accepted    = item_i.buffer_len;
        end
      end
      OP_PLAY: begin
        if (mode_q == M_STOPPED) begin
          if (cur_len_q != '0) begin
            mode_d = item_i.stereo_mode ? M_PLAY_STEREO : M_PLAY_MONO;
          end
        end else if (mode_q == M_PAUSE_MONO) begin
          mode_d = M_PLAY_MONO;
        end else if (mode_q == M_PAUSE_STEREO) begin
          mode_d = M_PLAY_STEREO;
        end
      end
      OP_PAUSE: begin
        if (mode_q == M_PLAY_MONO) begin
          mode_d = M_PAUSE_MONO;
        end else if (mode_q == M_PLAY_STEREO) begin
          mode_d = M_PAUSE_STEREO;
        end
      end
      OP_STOP: begin
        mode_d      = M_STOPPED;
        cur_base_d  = '0;
        cur_len_d   = '0;
        cur_pos_d   = '0;
        pend_base_d = '0;
        pend_len_d  = '0;
      end
      default: begin
        // undefined codes only report status
      end
    endcase
  end

  always_comb begin
    left = '0;
    if (cur_len_d != '0 && cur_pos_d <= POS_BITS'(cur_len_d)) begin
      left = POS_BITS'(cur_len_d) - cur_pos_d + POS_BITS'(pend_len_d);
    end
  end

  always_comb begin
    res_o.fetch_valid  = fetch;
    res_o.left_addr    = fetch ? laddr : '0;
    res_o.right_addr   = raddr;
    res_o.play_state   = mode_code(mode_d);
    res_o.bytes_left   = left;
    res_o.slot_free    = (pend_len_d == '0);
    res_o.accepted_len = accepted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_STOPPED;
      cur_base_q  <= '0;
      cur_len_q   <= '0;
      cur_pos_q   <= '0;
      pend_base_q <= '0;
      pend_len_q  <= '0;
      tick_q      <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      cur_base_q  <= cur_base_d;
      cur_len_q   <= cur_len_d;
      cur_pos_q   <= cur_pos_d;
      pend_base_q <= pend_base_d;
      pend_len_q  <= pend_len_d;
      tick_q      <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_div_q <= RATE_DIV_RST;
    end else if (cfg_we_i) begin
      rate_div_q <= cfg_data_i;
    end
  end

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("mode register not one-hot");

  a_empty_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_len_q == '0) |-> (cur_pos_q == '0))
    else $error("position nonzero with empty current slot");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pos_q <= POS_BITS'(cur_len_q))
    else $error("position past end of current buffer");

  a_active_has_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != M_STOPPED) |-> (cur_len_q != '0))
    else $error("playing or paused without a current buffer");

endmodule

`default_nettype wire

[src/dbass_out_stage.sv]
// Result register of the sequencer: holds one result beat until the sink takes it.
// Depends on dbass_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbass_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  dbass_pkg::result_t   res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dbass_pkg::result_t   out_data_o
);
  import dbass_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // room when empty or the held beat leaves this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

[src/double_buffered_audio_sample_sequencer_top.sv]
// Channel  | signals                           | direction
// ---------+-----------------------------------+----------
// command  | in_valid_i, in_stall_o, in_data_i | in
// result   | out_valid_o, out_stall_i, out_data_o | out
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i | in
//
// One command beat per cycle while the result is not stalled; each beat gives one
// result beat after passing the input register, then the result register. The core
// updates state as a beat moves from the input register into the result register.
// A stalled result holds the core and back-pressures the input register. Reset clears
// all state and sets the rate divisor to 11. Config writes are always ready.
// Depends on dbass_pkg, dbass_in_stage, dbass_core, dbass_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module double_buffered_audio_sample_sequencer_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  dbass_pkg::item_t               in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output dbass_pkg::result_t             out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [dbass_pkg::DIV_BITS-1:0]  cfg_data_i
);
  import dbass_pkg::*;

  logic    in_full;
  item_t   item;
  logic    out_free;
  logic    step;
  result_t res;

  assign step        = in_full && out_free;
  assign cfg_ready_o = 1'b1;

  dbass_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (out_free),
    .full_o     (in_full),
    .item_o     (item)
  );

  dbass_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  dbass_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
